FILE: design/adfs_pkg.sv
// ----------------------------------------------------------------------------
// adfs_pkg
// Shared constants for the ambient plus two-sided diffuse shading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package adfs_pkg;

	// shade scale applied to both gains
	localparam int unsigned SHADE_SCALE = 256;
	localparam int unsigned SS_W        = $clog2(SHADE_SCALE + 1);

	// configuration register indexes
	localparam int unsigned CFG_IDX_W     = 3;
	localparam logic [2:0]  REG_AMBIENT   = 3'd0;
	localparam logic [2:0]  REG_DIFFUSE   = 3'd1;
	localparam logic [2:0]  REG_LIGHT_X   = 3'd2;
	localparam logic [2:0]  REG_LIGHT_Y   = 3'd3;
	localparam logic [2:0]  REG_LIGHT_Z   = 3'd4;

	// reset values
	localparam logic [15:0] AMBIENT_RST = 16'd19661;
	localparam logic [15:0] DIFFUSE_RST = 16'd39322;
	localparam logic [31:0] LIGHT_X_RST = 32'hFFF6_0000;
	localparam logic [31:0] LIGHT_Y_RST = 32'h0064_0000;
	localparam logic [31:0] LIGHT_Z_RST = 32'h0032_0000;

	// square root: one result bit per stage; quotient: one bit per stage
	localparam int unsigned SQ_STEPS  = 31;
	localparam int unsigned DIV_STEPS = 20;
	localparam int unsigned DVD_W     = 49;

	localparam logic [7:0]  CH_MAX    = 8'hFF;

endpackage

`default_nettype wire

FILE: design/ambient_diffuse_face_shading_top.sv
// ----------------------------------------------------------------------------
// ambient_diffuse_face_shading_top
// Two-sided Lambert plus ambient shading of one surface sample per clock.
// ----------------------------------------------------------------------------
// A new sample is taken every clock while the output is not stalled; each
// result passes through the square root (one root bit per stage, 31 stages)
// and the cosine division (one quotient bit per stage, 20 stages) plus six
// arithmetic stages and the output register. A stall at the output holds the
// whole pipeline. Configuration writes are always ready and take effect at
// once, so write only while no sample is in flight.
`default_nettype none

module ambient_diffuse_face_shading_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [adfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [31:0]                         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [31:0]                  point_x,
	input  wire logic signed [31:0]                  point_y,
	input  wire logic signed [31:0]                  point_z,
	input  wire logic signed [15:0]                  normal_x,
	input  wire logic signed [15:0]                  normal_y,
	input  wire logic signed [15:0]                  normal_z,
	input  wire logic [23:0]                         base_color,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [23:0]                              shaded_color
);

	localparam int unsigned SQN = adfs_pkg::SQ_STEPS;
	localparam int unsigned DVN = adfs_pkg::DIV_STEPS;
	localparam int unsigned DW  = adfs_pkg::DVD_W;

	// configuration registers
	logic [15:0] ambient_q, diffuse_q;
	logic [31:0] light_x_q, light_y_q, light_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q <= adfs_pkg::AMBIENT_RST;
			diffuse_q <= adfs_pkg::DIFFUSE_RST;
			light_x_q <= adfs_pkg::LIGHT_X_RST;
			light_y_q <= adfs_pkg::LIGHT_Y_RST;
			light_z_q <= adfs_pkg::LIGHT_Z_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				adfs_pkg::REG_AMBIENT: ambient_q <= cfg_data[15:0];
				adfs_pkg::REG_DIFFUSE: diffuse_q <= cfg_data[15:0];
				adfs_pkg::REG_LIGHT_X: light_x_q <= cfg_data;
				adfs_pkg::REG_LIGHT_Y: light_y_q <= cfg_data;
				adfs_pkg::REG_LIGHT_Z: light_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances together unless the output is held
	logic out_valid_q;
	logic adv;
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	// ---------------- stage 1: light minus point ----------------
	logic               v_s1;
	logic signed [32:0] d_s1 [3];
	logic signed [15:0] n_s1 [3];
	logic [23:0]        base_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1[0] <= 33'(signed'(light_x_q)) - 33'(point_x);
			d_s1[1] <= 33'(signed'(light_y_q)) - 33'(point_y);
			d_s1[2] <= 33'(signed'(light_z_q)) - 33'(point_z);
			n_s1[0] <= normal_x;
			n_s1[1] <= normal_y;
			n_s1[2] <= normal_z;
			base_s1 <= base_color;
		end
	end

	// ---------------- stage 2: magnitudes and block scaling ----------------
	logic [32:0] neg_d [3];
	logic [31:0] mag   [3];
	logic [1:0]  kshift;
	logic [31:0] mag_sh [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_d[i]  = 33'(-d_s1[i]);
			mag[i]    = d_s1[i][32] ? neg_d[i][31:0] : d_s1[i][31:0];
		end
		if (mag[0][31] || mag[1][31] || mag[2][31])
			kshift = 2'd2;
		else if (mag[0][30] || mag[1][30] || mag[2][30])
			kshift = 2'd1;
		else
			kshift = 2'd0;
		for (int i = 0; i < 3; i++)
			mag_sh[i] = mag[i] >> kshift;
	end

	logic               v_s2;
	logic [29:0]        mm_s2  [3];
	logic signed [30:0] e_s2   [3];
	logic signed [15:0] n_s2   [3];
	logic [23:0]        base_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				mm_s2[i] <= mag_sh[i][29:0];
				e_s2[i]  <= d_s1[i][32] ? -signed'({1'b0, mag_sh[i][29:0]})
				                        : signed'({1'b0, mag_sh[i][29:0]});
				n_s2[i]  <= n_s1[i];
			end
			base_s2 <= base_s1;
		end
	end

	// ---------------- stage 3: squares and dot products ----------------
	logic               v_s3;
	logic [59:0]        sq_s3  [3];
	logic signed [46:0] p_s3   [3];
	logic [23:0]        base_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= 60'(mm_s2[i]) * 60'(mm_s2[i]);
				p_s3[i]  <= 47'(e_s2[i]) * 47'(n_s2[i]);
			end
			base_s3 <= base_s2;
		end
	end

	// ---------------- stage 4: sums ----------------
	logic               v_s4;
	logic [61:0]        len2_s4;
	logic signed [47:0] s_s4;
	logic [23:0]        base_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			len2_s4 <= 62'(sq_s3[0]) + 62'(sq_s3[1]) + 62'(sq_s3[2]);
			s_s4    <= 48'(p_s3[0]) + 48'(p_s3[1]) + 48'(p_s3[2]);
			base_s4 <= base_s3;
		end
	end

	logic [47:0] s_abs;
	assign s_abs = s_s4[47] ? 48'(-s_s4) : 48'(s_s4);

	// ---------------- square root: one root bit per stage ----------------
	logic          sv_s   [SQN];
	logic [63:0]   srem_s [SQN];
	logic [30:0]   sroot_s[SQN];
	logic [DW-1:0] sdvd_s [SQN];
	logic [23:0]   sbase_s[SQN];

	logic [63:0] sq_rem_in  [SQN];
	logic [30:0] sq_root_in [SQN];
	logic [63:0] sq_trial   [SQN];
	logic        sq_take    [SQN];

	always_comb begin
		for (int j = 0; j < SQN; j++) begin
			if (j == 0) begin
				sq_rem_in[j]  = 64'(len2_s4);
				sq_root_in[j] = '0;
			end else begin
				sq_rem_in[j]  = srem_s[j-1];
				sq_root_in[j] = sroot_s[j-1];
			end
			sq_trial[j] = (64'(sq_root_in[j]) << (SQN - j))
			            + (64'd1 << (2 * (SQN - 1 - j)));
			sq_take[j]  = sq_rem_in[j] >= sq_trial[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SQN; j++) sv_s[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < SQN; j++) begin
				if (j == 0) sv_s[j] <= v_s4;
				else sv_s[j] <= sv_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < SQN; j++) begin
				srem_s[j]  <= sq_take[j] ? sq_rem_in[j] - sq_trial[j] : sq_rem_in[j];
				sroot_s[j] <= sq_take[j] ? (sq_root_in[j] | (31'd1 << (SQN - 1 - j)))
				                         : sq_root_in[j];
				if (j == 0) begin
					sdvd_s[j]  <= {s_abs[DW-3:0], 2'b00};
					sbase_s[j] <= base_s4;
				end else begin
					sdvd_s[j]  <= sdvd_s[j-1];
					sbase_s[j] <= sbase_s[j-1];
				end
			end
		end
	end

	// ---------------- division: one quotient bit per stage ----------------
	logic          dv_s   [DVN];
	logic [31:0]   drem_s [DVN];
	logic [DVN-1:0] dq_s  [DVN];
	logic [30:0]   dlen_s [DVN];
	logic          dzero_s[DVN];
	logic [DW-1:0] ddvd_s [DVN];
	logic [23:0]   dbase_s[DVN];

	logic [31:0]    dv_rem_in [DVN];
	logic [30:0]    dv_len_in [DVN];
	logic [DW-1:0]  dv_dvd_in [DVN];
	logic [DVN-1:0] dv_q_in   [DVN];
	logic [31:0]    dv_shift  [DVN];
	logic           dv_take   [DVN];

	always_comb begin
		for (int j = 0; j < DVN; j++) begin
			if (j == 0) begin
				// quotient stays below 2^DVN, so the top part is below len
				dv_rem_in[j] = 32'(sdvd_s[SQN-1][DW-1:DVN]);
				dv_len_in[j] = sroot_s[SQN-1];
				dv_dvd_in[j] = sdvd_s[SQN-1];
				dv_q_in[j]   = '0;
			end else begin
				dv_rem_in[j] = drem_s[j-1];
				dv_len_in[j] = dlen_s[j-1];
				dv_dvd_in[j] = ddvd_s[j-1];
				dv_q_in[j]   = dq_s[j-1];
			end
			dv_shift[j] = {dv_rem_in[j][30:0], dv_dvd_in[j][DVN-1-j]};
			dv_take[j]  = dv_shift[j] >= 32'(dv_len_in[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DVN; j++) dv_s[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < DVN; j++) begin
				if (j == 0) dv_s[j] <= sv_s[SQN-1];
				else dv_s[j] <= dv_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < DVN; j++) begin
				drem_s[j] <= dv_take[j] ? dv_shift[j] - 32'(dv_len_in[j]) : dv_shift[j];
				dq_s[j]   <= dv_take[j] ? (dv_q_in[j] | (DVN'(1) << (DVN - 1 - j)))
				                        : dv_q_in[j];
				dlen_s[j] <= dv_len_in[j];
				ddvd_s[j] <= dv_dvd_in[j];
				if (j == 0) begin
					dzero_s[j] <= (sroot_s[SQN-1] == '0);
					dbase_s[j] <= sbase_s[SQN-1];
				end else begin
					dzero_s[j] <= dzero_s[j-1];
					dbase_s[j] <= dbase_s[j-1];
				end
			end
		end
	end

	// ---------------- gains ----------------
	logic [DVN-1:0] cosv;
	assign cosv = dzero_s[DVN-1] ? '0 : dq_s[DVN-1];

	localparam int unsigned ACC_W = DVN + 17;
	localparam int unsigned T_W   = ACC_W + adfs_pkg::SS_W;

	logic             v_s5;
	logic [ACC_W-1:0] acc_s5;
	logic [23:0]      base_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= dv_s[DVN-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5  <= ACC_W'(cosv) * ACC_W'(diffuse_q) + (ACC_W'(ambient_q) << 16);
			base_s5 <= dbase_s[DVN-1];
		end
	end

	logic           v_s6;
	logic [T_W-1:0] t_s6;
	logic [23:0]    base_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s6    <= T_W'(acc_s5) * T_W'(adfs_pkg::SHADE_SCALE);
			base_s6 <= base_s5;
		end
	end

	// ---------------- channel add and saturate ----------------
	logic [T_W-33:0] tadd;
	logic [T_W-32:0] chsum [3];
	logic [23:0]     lit;

	assign tadd = t_s6[T_W-1:32];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			chsum[i] = (T_W-31)'(base_s6[8*i +: 8]) + (T_W-31)'(tadd);
			lit[8*i +: 8] = (chsum[i] > (T_W-31)'(adfs_pkg::CH_MAX))
			              ? adfs_pkg::CH_MAX : chsum[i][7:0];
		end
	end

	logic [23:0] shaded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) shaded_q <= lit;
	end

	assign out_valid    = out_valid_q;
	assign shaded_color = shaded_q;

endmodule

`default_nettype wire
